/* sv/scrf_pkg.sv */
// ----------------------------------------------------------------------------
// scrf_pkg
// Types and constants shared by the serial controller register file modules.
// ----------------------------------------------------------------------------
package scrf_pkg;

    // one bus access or baud tick
    typedef struct packed {
        logic       no_op;
        logic       port;
        logic       channel;
        logic [1:0] action;
        logic [7:0] value;
    } scrf_item_t;

    // events that one channel's write raises for every channel
    typedef struct packed {
        logic wr2;
        logic rst_a;
        logic rst_b;
        logic rst_hard;
    } scrf_event_t;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic PORT_CMD = 1'b0;

    localparam logic [7:0] REG_R0   = 8'd0;
    localparam logic [7:0] REG_WR2  = 8'd2;
    localparam logic [7:0] REG_WR3  = 8'd3;
    localparam logic [7:0] REG_WR4  = 8'd4;
    localparam logic [7:0] REG_WR5  = 8'd5;
    localparam logic [7:0] REG_WR6  = 8'd6;
    localparam logic [7:0] REG_WR7  = 8'd7;
    localparam logic [7:0] REG_WR8  = 8'd8;
    localparam logic [7:0] REG_WR9  = 8'h09;
    localparam logic [7:0] REG_WR11 = 8'h0B;
    localparam logic [7:0] REG_WR12 = 8'd12;
    localparam logic [7:0] REG_WR13 = 8'd13;
    localparam logic [7:0] REG_WR14 = 8'd14;
    localparam logic [7:0] REG_WR15 = 8'd15;

    localparam logic [1:0] WR9_RST_B  = 2'b01;
    localparam logic [1:0] WR9_RST_A  = 2'b10;
    localparam logic [1:0] WR9_RST_HW = 2'b11;

    localparam logic [7:0] WR4_RESET_BITS = 8'h04;
    localparam logic [7:0] WR11_RESET     = 8'h08;
    localparam logic [7:0] WR15_READ_MASK = 8'hfa;

    localparam int REGS_PER_CH = 16;

endpackage

/* sv/scrf_channel.sv */
// ----------------------------------------------------------------------------
// scrf_channel
// One channel: register pointer, write registers, transmit holding byte and
// the baud rate generator.
// ----------------------------------------------------------------------------
module scrf_channel
    import scrf_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        hit,
    input  scrf_item_t  item,
    input  scrf_event_t glob,
    output scrf_event_t ev,
    output logic [7:0]  read_data,
    output logic        baud_pulse
);

    logic [7:0]  regs_reg [REGS_PER_CH];
    logic [7:0]  regs_next [REGS_PER_CH];
    logic [7:0]  sel_reg, sel_next;
    logic        armed_reg, armed_next;
    logic        tx_empty_reg, tx_empty_next;
    logic [7:0]  tx_hold_reg, tx_hold_next;
    logic [15:0] count_reg, count_next;
    logic        ff_reg, ff_next;

    logic        is_write;
    logic        is_read;
    logic        is_tick;
    logic        store_en;
    logic        soft_me;
    logic [15:0] time_const;

    assign is_write = hit && item.action == ACT_WRITE && item.port == PORT_CMD;
    assign is_read  = hit && item.action == ACT_READ && item.port == PORT_CMD && !item.no_op;
    assign is_tick  = hit && item.action == ACT_TICK;
    assign store_en = is_write && armed_reg;
    assign time_const = {regs_reg[REG_WR13[3:0]], regs_reg[REG_WR12[3:0]]};

    assign ev.wr2      = store_en && sel_reg == REG_WR2;
    assign ev.rst_b    = store_en && sel_reg == REG_WR9 && item.value[7:6] == WR9_RST_B;
    assign ev.rst_a    = store_en && sel_reg == REG_WR9 && item.value[7:6] == WR9_RST_A;
    assign ev.rst_hard = store_en && sel_reg == REG_WR9 && item.value[7:6] == WR9_RST_HW;

    assign soft_me = glob.rst_hard || (glob.rst_a && IDX == 0) || (glob.rst_b && IDX == 1);

    always_comb
    begin
        regs_next     = regs_reg;
        sel_next      = sel_reg;
        armed_next    = armed_reg;
        tx_empty_next = tx_empty_reg;
        tx_hold_next  = tx_hold_reg;
        count_next    = count_reg;
        ff_next       = ff_reg;
        read_data     = 8'd0;
        baud_pulse    = 1'b0;

        if (is_write)
        begin
            if (!armed_reg)
            begin
                sel_next   = item.value;
                armed_next = 1'b1;
            end
            else
            begin
                sel_next   = 8'd0;
                armed_next = 1'b0;
                case (sel_reg)
                    REG_WR3, REG_WR4, REG_WR5, REG_WR6, REG_WR7,
                    REG_WR11, REG_WR12, REG_WR13, REG_WR15:
                    begin
                        regs_next[sel_reg[3:0]] = item.value;
                    end
                    REG_WR8:
                    begin
                        tx_hold_next  = item.value;
                        tx_empty_next = 1'b0;
                    end
                    REG_WR14:
                    begin
                        regs_next[REG_WR14[3:0]] = item.value;
                        // generator enable rising: restart from time constant
                        if (!regs_reg[REG_WR14[3:0]][0] && item.value[0])
                        begin
                            count_next = time_const;
                            ff_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (is_read)
        begin
            sel_next   = 8'd0;
            armed_next = 1'b0;
            case (sel_reg)
                REG_R0:   read_data = {5'd0, tx_empty_reg, 2'd0};
                REG_WR2:  read_data = regs_reg[REG_WR2[3:0]];
                REG_WR12: read_data = regs_reg[REG_WR12[3:0]];
                REG_WR9, REG_WR13: read_data = regs_reg[REG_WR13[3:0]];
                REG_WR11, REG_WR15: read_data = regs_reg[REG_WR15[3:0]] & WR15_READ_MASK;
                default:  read_data = 8'd0;
            endcase
        end
        else if (is_tick)
        begin
            if (regs_reg[REG_WR14[3:0]][0])
            begin
                if (count_reg == 16'd0)
                begin
                    count_next = time_const;
                    ff_next    = !ff_reg;
                    baud_pulse = ff_reg;
                end
                else
                begin
                    count_next = count_reg - 16'd1;
                end
            end
        end

        if (glob.wr2)
        begin
            regs_next[REG_WR2[3:0]] = item.value;
        end

        if (glob.rst_hard)
        begin
            for (int n = 0; n < REGS_PER_CH; n++)
            begin
                regs_next[n] = 8'd0;
            end
            regs_next[REG_WR11[3:0]] = WR11_RESET;
        end

        // channel reset keeps the pointer and the holding byte
        if (soft_me)
        begin
            regs_next[REG_WR4[3:0]] = regs_next[REG_WR4[3:0]] | WR4_RESET_BITS;
            tx_empty_next = 1'b1;
            count_next    = {regs_next[REG_WR13[3:0]], regs_next[REG_WR12[3:0]]};
            ff_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < REGS_PER_CH; n++)
            begin
                regs_reg[n] <= 8'd0;
            end
            regs_reg[REG_WR4[3:0]]  <= WR4_RESET_BITS;
            regs_reg[REG_WR11[3:0]] <= WR11_RESET;
            sel_reg      <= 8'd0;
            armed_reg    <= 1'b0;
            tx_empty_reg <= 1'b1;
            tx_hold_reg  <= 8'd0;
            count_reg    <= 16'd0;
            ff_reg       <= 1'b1;
        end
        else if (advance)
        begin
            regs_reg     <= regs_next;
            sel_reg      <= sel_next;
            armed_reg    <= armed_next;
            tx_empty_reg <= tx_empty_next;
            tx_hold_reg  <= tx_hold_next;
            count_reg    <= count_next;
            ff_reg       <= ff_next;
        end
    end

    a_hard_reset_wr11: assert property (@(posedge clk) disable iff (!rst_n)
        advance && glob.rst_hard |=> regs_reg[REG_WR11[3:0]] == WR11_RESET)
        else $error("wr11 not restored by hardware reset");

    a_pulse_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        advance && baud_pulse |=> !ff_reg && count_reg == $past(time_const))
        else $error("baud pulse without flip-flop toggle and reload");

    a_select_arms: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_write && !armed_reg |=> armed_reg && sel_reg == $past(item.value))
        else $error("pointer not armed after selection");

    a_reset_tx_empty: assert property (@(posedge clk) disable iff (!rst_n)
        advance && soft_me |=> tx_empty_reg && ff_reg)
        else $error("channel reset did not set tx empty");

endmodule

/* sv/serial_controller_register_file.sv */
// ----------------------------------------------------------------------------
// serial_controller_register_file
// Command-port register interface and baud generators of a two-channel
// serial controller.
// ----------------------------------------------------------------------------
// Every accepted word (bus write, bus read or baud tick) gives exactly one
// result word. Words pass through an input register and a result register:
// the channel update and the result are computed between the two, and the
// result register loads a word from the input register once the result side
// is empty or being read, and a new word is taken in every
// cycle while the result side keeps up. Channel state changes when a word
// moves into the result register, so each word sees all earlier words. There
// is no clearing pass after reset.
module serial_controller_register_file
    import scrf_pkg::*;
#(
    parameter int NUM_CHANNELS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // value
    input  logic [4:0]  s_axis_tuser,   // action[1:0], channel, port, no_op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_data[7:0], baud_pulse, zero pad
);

    logic        in_valid_reg;
    scrf_item_t  in_item_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        advance;

    scrf_event_t ev [NUM_CHANNELS];
    logic [7:0]  rd_ch [NUM_CHANNELS];
    logic        pulse_ch [NUM_CHANNELS];
    scrf_event_t glob;
    logic [7:0]  rd_any;
    logic        pulse_any;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.value   <= s_axis_tdata;
            in_item_reg.action  <= s_axis_tuser[1:0];
            in_item_reg.channel <= s_axis_tuser[2];
            in_item_reg.port    <= s_axis_tuser[3];
            in_item_reg.no_op   <= s_axis_tuser[4];
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++)
        begin : g_ch
            scrf_channel #(
                .IDX(g)
            ) u_channel (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .hit        (in_item_reg.channel == 1'(g)),
                .item       (in_item_reg),
                .glob       (glob),
                .ev         (ev[g]),
                .read_data  (rd_ch[g]),
                .baud_pulse (pulse_ch[g])
            );
        end
    endgenerate

    // only the addressed channel raises events or returns data
    always_comb
    begin
        glob      = '0;
        rd_any    = 8'd0;
        pulse_any = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            glob.wr2      = glob.wr2 | ev[i].wr2;
            glob.rst_a    = glob.rst_a | ev[i].rst_a;
            glob.rst_b    = glob.rst_b | ev[i].rst_b;
            glob.rst_hard = glob.rst_hard | ev[i].rst_hard;
            rd_any        = rd_any | rd_ch[i];
            pulse_any     = pulse_any | pulse_ch[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {7'd0, pulse_any, rd_any};
        end
    end

endmodule
